@@ src/lbcd_pkg.sv @@
package lbcd_pkg;

    // Request beat: key, address and size of one stored item
    typedef struct packed {
        logic [31:0] req_key;
        logic [31:0] req_addr;
        logic [24:0] req_size;
    } t_req;

    // Response beat: lookup outcome and the entry that now holds the key
    typedef struct packed {
        logic        hit;
        logic [2:0]  slot;
        logic [31:0] entry_addr;
        logic [24:0] entry_size;
        logic        evicted_valid;
        logic [31:0] evicted_key;
    } t_rsp;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;    // capture the request beat
        logic commit;  // update the directory and load the response register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;  // response register can take a beat this cycle
    } t_sts;

endpackage

@@ src/lbcd_ctrl.sv @@
module lbcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  lbcd_pkg::t_sts    i_sts,
    output lbcd_pkg::t_cmd    o_cmd,
    output logic              o_req_stall
);

    lbcd_pkg::t_state r_state;
    lbcd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lbcd_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = lbcd_pkg::ST_WORK;
                end
            end
            lbcd_pkg::ST_WORK: begin
                if (i_sts.out_free) begin
                    n_state = lbcd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lbcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd       = '0;
        o_req_stall = 1'b1;
        case (r_state)
            lbcd_pkg::ST_IDLE: begin
                o_req_stall = 1'b0;
                o_cmd.load  = i_req_valid;
            end
            lbcd_pkg::ST_WORK: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_req_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ src/lbcd_dp.sv @@
module lbcd_dp #(
    parameter int ENTRIES   = 5,
    parameter int KEY_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbcd_pkg::t_cmd    i_cmd,
    output lbcd_pkg::t_sts    o_sts,
    input  lbcd_pkg::t_req    i_req,
    output logic              o_rsp_valid,
    output lbcd_pkg::t_rsp    o_rsp,
    input  logic              i_rsp_stall
);

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Captured request
    logic [KEY_WIDTH-1:0] r_req_key;
    logic [31:0]          r_req_addr;
    logic [24:0]          r_req_size;

    // Directory entries
    logic [KEY_WIDTH-1:0] r_key  [ENTRIES];
    logic [31:0]          r_base [ENTRIES];
    logic [24:0]          r_len  [ENTRIES];
    logic                 r_valid[ENTRIES];
    logic [SW-1:0]        r_rank [ENTRIES];

    // Response register
    lbcd_pkg::t_rsp r_rsp;
    logic           r_rsp_valid;

    logic [KEY_WIDTH+31:0] req_key_wide;
    logic [KEY_WIDTH-1:0]  req_key;
    logic [ENTRIES-1:0]    match;
    logic                  hit;
    logic [SW-1:0]         hit_idx;
    logic [SW-1:0]         vic_idx;
    logic [SW-1:0]         sel;
    logic [SW-1:0]         old_rank;
    logic [SW+2:0]         sel_wide;
    logic [KEY_WIDTH+31:0] ev_key_wide;
    logic                  ev_valid;
    lbcd_pkg::t_rsp        n_rsp;

    // Keep the low KEY_WIDTH bits of the key, zero-extend when wider
    assign req_key_wide = {{KEY_WIDTH{1'b0}}, i_req.req_key};
    assign req_key      = req_key_wide[KEY_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_key  <= req_key;
            r_req_addr <= i_req.req_addr;
            r_req_size <= i_req.req_size;
        end
    end

    // Parallel tag compare; lowest matching slot wins
    always_comb begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_key[i] == r_req_key);
            if (match[i]) begin
                hit_idx = SW'(i);
            end
        end
        hit = |match;
    end

    // Ranks are a permutation, so the victim holds the highest rank
    always_comb begin
        vic_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_rank[i] == SW'(ENTRIES - 1)) begin
                vic_idx = SW'(i);
            end
        end
    end

    assign sel      = hit ? hit_idx : vic_idx;
    assign old_rank = r_rank[sel];
    assign sel_wide = {3'b000, sel};
    assign ev_valid = !hit && r_valid[sel];
    assign ev_key_wide = {32'd0, r_key[sel]};

    always_comb begin
        n_rsp.hit           = hit;
        n_rsp.slot          = sel_wide[2:0];
        n_rsp.entry_addr    = hit ? r_base[sel] : r_req_addr;
        n_rsp.entry_size    = hit ? r_len[sel]  : r_req_size;
        n_rsp.evicted_valid = ev_valid;
        n_rsp.evicted_key   = ev_valid ? ev_key_wide[31:0] : 32'd0;
    end

    // Entry payload: write the victim on a miss
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !hit) begin
            r_key[sel]  <= r_req_key;
            r_base[sel] <= r_req_addr;
            r_len[sel]  <= r_req_size;
        end
    end

    // Valid bits and recency ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= SW'(i);
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (SW'(i) == sel) begin
                    r_valid[i] <= 1'b1;
                    r_rank[i]  <= '0;
                end else if (r_rank[i] < old_rank) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
        end
    end

    assign o_sts.out_free = !r_rsp_valid || !i_rsp_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

@@ src/lru_bitstream_cache_directory.sv @@
// Flow: the request beat is captured on accept, then the lookup and commit step loads the response register.
// The request side takes a beat only in the idle state, so no new request is taken until the last one has
// committed; the commit step waits while the response register holds an unaccepted beat.
// Reset (i_rst_n low, synchronous): all entries invalid, slot i gets recency rank i,
// controller idle, response register empty. Stored keys, addresses and sizes are not cleared.
module lru_bitstream_cache_directory #(
    parameter int ENTRIES   = 5,
    parameter int KEY_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel
    input  logic              i_req_valid,
    input  lbcd_pkg::t_req    i_req,
    output logic              o_req_stall,
    // Response channel
    output logic              o_rsp_valid,
    output lbcd_pkg::t_rsp    o_rsp,
    input  logic              i_rsp_stall
);

    // Command and status between the sequencer and the directory datapath
    lbcd_pkg::t_cmd cmd;
    lbcd_pkg::t_sts sts;

    // Sequencer: idle -> take a request beat; work -> commit once the
    // response register is free, then drop back to idle.
    lbcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_req_stall (o_req_stall)
    );

    // Directory: parallel key compare over all entries, victim pick by rank,
    // entry write on a miss, recency update, and the registered response beat.
    lbcd_dp #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_rsp_stall (i_rsp_stall)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int ENTRIES     = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 650;

    // Predicts each lookup and checks responses in order.
    class lru_scoreboard;
        logic [31:0] tag_q[ENTRIES];
        bit          live_q[ENTRIES];
        logic [31:0] base_q[ENTRIES];
        logic [24:0] len_q[ENTRIES];
        int unsigned age_q[ENTRIES];
        lbcd_pkg::t_rsp lookups_due[$];
        int          errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                live_q[i] = 1'b0;
                age_q[i]  = i;
            end
            errors = 0;
        endfunction

        // Compute the response of one accepted request beat and update the directory.
        function void note_lookup(lbcd_pkg::t_req beat);
            lbcd_pkg::t_rsp want;
            int unsigned pick;
            int unsigned old_age;
            int unsigned worst;
            bit          found;
            want  = '0;
            pick  = 0;
            found = 1'b0;
            // Lowest matching valid slot wins; invalid slots never match.
            for (int i = 0; i < ENTRIES; i++) begin
                if (!found && live_q[i] && tag_q[i] == beat.req_key) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                // Victim is the oldest slot, lowest index on a tie.
                worst = age_q[0];
                for (int i = 1; i < ENTRIES; i++) begin
                    if (age_q[i] > worst) begin
                        worst = age_q[i];
                        pick  = i;
                    end
                end
                if (live_q[pick]) begin
                    want.evicted_valid = 1'b1;
                    want.evicted_key   = tag_q[pick];
                end
                tag_q[pick]  = beat.req_key;
                base_q[pick] = beat.req_addr;
                len_q[pick]  = beat.req_size;
                live_q[pick] = 1'b1;
            end
            // Promote the chosen slot; everything younger ages by one.
            old_age = age_q[pick];
            for (int i = 0; i < ENTRIES; i++) begin
                if (i != pick && age_q[i] < old_age) age_q[i]++;
            end
            age_q[pick] = 0;
            want.hit        = found;
            want.slot       = pick[2:0];
            want.entry_addr = base_q[pick];
            want.entry_size = len_q[pick];
            lookups_due.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_lookup(lbcd_pkg::t_rsp got);
            lbcd_pkg::t_rsp want;
            if (lookups_due.size() == 0) begin
                $error("response beat with nothing outstanding: %0h", got);
                errors++;
            end else begin
                want = lookups_due.pop_front();
                compare_field("hit", 32'(want.hit), 32'(got.hit));
                compare_field("slot", 32'(want.slot), 32'(got.slot));
                compare_field("entry_addr", want.entry_addr, got.entry_addr);
                compare_field("entry_size", 32'(want.entry_size), 32'(got.entry_size));
                compare_field("evicted_valid", 32'(want.evicted_valid),
                              32'(got.evicted_valid));
                compare_field("evicted_key", want.evicted_key, got.evicted_key);
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    lbcd_pkg::t_req req_beat = '0;
    logic rsp_stall = 1'b0;
    logic o_req_stall;
    logic o_rsp_valid;
    lbcd_pkg::t_rsp o_rsp;

    lru_scoreboard board;
    bit            quiet      = 1'b0;  // no gaps and no stalls while set
    int            stall_left = 0;
    int            cycles     = 0;
    logic [31:0]   key_pool[8];

    lru_bitstream_cache_directory dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .i_req      (req_beat),
        .o_req_stall(o_req_stall),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp),
        .i_rsp_stall(rsp_stall)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bound the run; a hang counts as a failure.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly zero, often short, now and then long.
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Response-side back-pressure: hold stall for a random run, then pick again.
    always @(posedge clk) begin
        if (!rst_n || quiet) begin
            rsp_stall  <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_left = pick_pause();
            rsp_stall  <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Check every response beat taken at this edge.
    always @(posedge clk) begin
        if (rst_n && o_rsp_valid && !rsp_stall) board.check_lookup(o_rsp);
    end

    // Present one request beat, hold it until taken, then drop valid for the gap.
    task automatic send_lookup(input lbcd_pkg::t_req beat, input int gap);
        req_valid <= 1'b1;
        req_beat  <= beat;
        do @(posedge clk); while (o_req_stall);
        board.note_lookup(beat);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic lookup(input logic [31:0] key, input logic [31:0] addr,
                          input logic [24:0] size);
        lbcd_pkg::t_req beat;
        beat.req_key  = key;
        beat.req_addr = addr;
        beat.req_size = size;
        send_lookup(beat, pick_pause());
    endtask

    task automatic wait_all_back();
        while (board.lookups_due.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] fresh_key();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 32'h0;
        if (roll == 1) return 32'hffff_ffff;
        return $urandom;
    endfunction

    initial begin
        logic [31:0] key;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: fill from empty, extremes of every field, hits on the newest and
        // oldest entries, evictions, and a re-request of an evicted key.
        lookup(32'h0000_0000, 32'h0000_0000, 25'h0000000);     // key zero misses after reset
        lookup(32'hffff_ffff, 32'hffff_ffff, 25'h1ffffff);
        lookup(32'h0000_0000, 32'h1234_5678, 25'h0abcdef);     // hit returns stored values
        lookup(32'h0000_0000, 32'hffff_ffff, 25'h1ffffff);     // hit on the newest
        lookup(32'h0000_0001, 32'h8000_0000, 25'h1000000);
        lookup(32'h8000_0000, 32'h0000_0001, 25'h0000001);
        lookup(32'haaaa_5555, 32'h5555_aaaa, 25'h0aaaaaa);     // directory now full
        lookup(32'hffff_ffff, 32'h0, 25'h0);                   // hit on the oldest
        lookup(32'h5555_aaaa, 32'haaaa_5555, 25'h1555555);     // first eviction
        lookup(32'h0000_0002, 32'hdead_beef, 25'h0123456);     // evicts again
        lookup(32'h0000_0000, 32'h0000_0000, 25'h0000000);     // evicted key comes back
        lookup(32'h8000_0000, 32'h1111_1111, 25'h1111111);
        lookup(32'h8000_0000, 32'h2222_2222, 25'h0222222);     // back-to-back hit
        lookup(32'hffff_fffe, 32'hffff_fffe, 25'h1fffffe);
        lookup(32'h7fff_ffff, 32'h7fff_ffff, 25'h0ffffff);
        lookup(32'h0000_0001, 32'h0, 25'h0);
        lookup(32'hffff_ffff, 32'hffff_ffff, 25'h1ffffff);
        lookup(32'h0000_0002, 32'h0, 25'h0);
        lookup(32'h5555_aaaa, 32'h0, 25'h0);
        lookup(32'hffff_fffe, 32'h0, 25'h0);

        // Random: a pool a little larger than the directory keeps hits and
        // evictions both frequent; the pool drifts over the run.
        foreach (key_pool[i]) key_pool[i] = fresh_key();
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            quiet = (n >= 200 && n < 260) || (n >= 500 && n < 540);
            if (n % 60 == 59) key_pool[$urandom_range(0, 7)] = fresh_key();
            if ($urandom_range(0, 99) < 85) begin
                // Narrow the pool now and then so the same few keys keep hitting.
                key = key_pool[$urandom_range(0, ($urandom_range(0, 2) == 0) ? 3 : 7)];
            end else begin
                key = fresh_key();
            end
            lookup(key, $urandom, 25'($urandom));
            if (n == 320) begin
                // Pause the sender until the directory has answered everything.
                req_valid <= 1'b0;
                @(posedge clk);
                wait_all_back();
            end
        end
        quiet = 1'b0;
        req_valid <= 1'b0;

        wait_all_back();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.lookups_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/lbcd_pkg.sv
src/lbcd_ctrl.sv
src/lbcd_dp.sv
src/lru_bitstream_cache_directory.sv
tb/tb.sv
